### rtl/core/spf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_pkg: shared types and constants of the sequenced packet framer
// Word formats, configuration record, queue entry and modulo unit sizing.
// ----------------------------------------------------------------------------
package spf_pkg;

    // Kinds of frame word.
    localparam logic [1:0] KIND_START    = 2'd0;
    localparam logic [1:0] KIND_SEQ      = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD  = 2'd2;
    localparam logic [1:0] KIND_CHECKSUM = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_START_BYTE = 2'd0;
    localparam logic [1:0] REG_MODULUS    = 2'd1;
    localparam logic [1:0] REG_SEQ_FIRST  = 2'd2;
    localparam logic [1:0] REG_SEQ_WRAP   = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    // Reset values of the configuration and of the sequence number, and the largest modulus.
    localparam logic [7:0] START_BYTE_RESET = 8'h01;
    localparam logic [8:0] MODULUS_RESET    = 9'd256;
    localparam logic [8:0] MODULUS_MAX      = 9'd256;
    localparam logic [7:0] SEQ_FIRST_RESET  = 8'd1;
    localparam logic [7:0] SEQ_WRAP_RESET   = 8'd255;
    localparam logic [7:0] SEQ_RESET        = 8'd1;

    // Modulo unit: 9-bit dividend, three remainder bits per cycle.
    localparam int SUM_W           = 9;
    localparam int RED_BITS_PER_CY = 3;
    localparam int RED_CYCLES      = SUM_W / RED_BITS_PER_CY;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] byte_kind;
        logic       end_of_run;
    } out_word_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_byte;
        logic       first_byte;
    } entry_t;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [8:0] modulus;      // effective modulus, 1 to 256
        logic [7:0] seq_first;
        logic [7:0] seq_wrap_limit;
    } cfg_t;

endpackage

### rtl/core/spf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_front: input side of the framer
// Accepts payload words and marks the one that opens a frame.
// ----------------------------------------------------------------------------
module spf_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  spf_pkg::in_word_t byte_word,
    input  logic              q_full,
    output logic              q_push,
    output spf_pkg::entry_t   q_entry
);
    import spf_pkg::*;

    logic in_frame_reg;
    logic in_frame_next;

    assign byte_stall = q_full;
    assign q_push     = byte_valid && !q_full;

    assign q_entry.payload_byte = byte_word.payload_byte;
    assign q_entry.last_byte    = byte_word.last_byte;
    assign q_entry.first_byte   = !in_frame_reg;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        if (q_push)
        begin
            in_frame_next = !byte_word.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
        end
    end

endmodule

### rtl/core/spf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_queue: short queue between front and back
// Holds classified words so that either side can stall on its own.
// ----------------------------------------------------------------------------
module spf_queue #(
    parameter int DEPTH = spf_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  spf_pkg::entry_t push_entry,
    input  logic            pop,
    output spf_pkg::entry_t head,
    output logic            full,
    output logic            empty
);
    import spf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/core/spf_modred.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_modred: iterative modulo unit
// Restoring remainder of a 9-bit value, three dividend bits per cycle.
// ----------------------------------------------------------------------------
module spf_modred (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [spf_pkg::SUM_W-1:0] value,
    input  logic [8:0]                modulus,
    output logic                      done,
    output logic [7:0]                result
);
    import spf_pkg::*;

    localparam int CNT_W = (RED_CYCLES > 1) ? $clog2(RED_CYCLES) : 1;

    logic [SUM_W-1:0] val_reg;
    logic [SUM_W-1:0] val_next;
    logic [8:0]       rem_reg;
    logic [8:0]       rem_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;

    assign done   = done_reg;
    // The remainder is below the modulus, which is at most 256.
    assign result = rem_reg[7:0];

    always_comb
    begin
        logic [9:0]       trial;
        logic [8:0]       rem_w;
        logic [SUM_W-1:0] val_w;

        rem_w     = rem_reg;
        val_w     = val_reg;
        trial     = '0;
        val_next  = val_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            val_next  = value;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            for (int j = 0; j < RED_BITS_PER_CY; j++)
            begin
                trial = {rem_w, val_w[SUM_W-1]};
                if (trial >= {1'b0, modulus})
                begin
                    trial = trial - {1'b0, modulus};
                end
                rem_w = trial[8:0];
                val_w = {val_w[SUM_W-2:0], 1'b0};
            end
            rem_next = rem_w;
            val_next = val_w;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(RED_CYCLES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        rem_reg <= rem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule

### rtl/core/spf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_back: frame builder
// Takes queued words, emits start, sequence, payload and checksum words,
// and keeps the sequence number and the reduced running sum.
// ----------------------------------------------------------------------------
module spf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  spf_pkg::cfg_t      cfg,
    input  logic               q_empty,
    input  spf_pkg::entry_t    q_head,
    output logic               q_pop,
    output logic               frame_valid,
    input  logic               frame_stall,
    output spf_pkg::out_word_t frame_word
);
    import spf_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_SEQ   = 7'b0000100,
        S_RSEQ  = 7'b0001000,
        S_RDAT  = 7'b0010000,
        S_PAY   = 7'b0100000,
        S_CHK   = 7'b1000000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    entry_t           entry_reg;
    entry_t           entry_next;
    logic [7:0]       seq_reg;
    logic [7:0]       seq_next;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    out_word_t        out_word_reg;
    out_word_t        out_word_next;
    logic             can_load;
    logic             red_start;
    logic [SUM_W-1:0] red_value;
    logic             red_done;
    logic [7:0]       red_result;
    logic [8:0]       seq_inc;

    assign frame_valid = out_valid_reg;
    assign frame_word  = out_word_reg;
    assign can_load    = !out_valid_reg || !frame_stall;
    assign seq_inc     = {1'b0, seq_reg} + 9'd1;

    spf_modred u_modred (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (red_start),
        .value   (red_value),
        .modulus (cfg.modulus),
        .done    (red_done),
        .result  (red_result)
    );

    always_comb
    begin
        state_next     = state_reg;
        entry_next     = entry_reg;
        seq_next       = seq_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        q_pop          = 1'b0;
        red_start      = 1'b0;
        red_value      = {1'b0, sum_reg} + {1'b0, entry_reg.payload_byte};

        if (out_valid_reg && !frame_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    entry_next = q_head;
                    if (q_head.first_byte)
                    begin
                        state_next = S_START;
                    end
                    else
                    begin
                        red_start  = 1'b1;
                        red_value  = {1'b0, sum_reg} + {1'b0, q_head.payload_byte};
                        state_next = S_RDAT;
                    end
                end
            end
            S_START:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = '{out_byte: cfg.start_byte, byte_kind: KIND_START,
                                       end_of_run: 1'b0};
                    state_next     = S_SEQ;
                end
            end
            S_SEQ:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = '{out_byte: seq_reg, byte_kind: KIND_SEQ,
                                       end_of_run: 1'b0};
                    red_start      = 1'b1;
                    red_value      = {1'b0, seq_reg};
                    state_next     = S_RSEQ;
                end
            end
            S_RSEQ:
            begin
                if (red_done)
                begin
                    sum_next   = red_result;
                    red_start  = 1'b1;
                    red_value  = {1'b0, red_result} + {1'b0, entry_reg.payload_byte};
                    state_next = S_RDAT;
                end
            end
            S_RDAT:
            begin
                if (red_done)
                begin
                    sum_next   = red_result;
                    state_next = S_PAY;
                end
            end
            S_PAY:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = '{out_byte: entry_reg.payload_byte,
                                       byte_kind: KIND_PAYLOAD,
                                       end_of_run: !entry_reg.last_byte};
                    state_next     = entry_reg.last_byte ? S_CHK : S_IDLE;
                end
            end
            S_CHK:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = '{out_byte: sum_reg, byte_kind: KIND_CHECKSUM,
                                       end_of_run: 1'b1};
                    // The increment is taken at nine bits, so 255 never rolls to 0.
                    if (seq_inc > {1'b0, cfg.seq_wrap_limit})
                    begin
                        seq_next = cfg.seq_first;
                    end
                    else
                    begin
                        seq_next = seq_inc[7:0];
                    end
                    sum_next   = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg    <= entry_next;
        out_word_reg <= out_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seq_reg       <= SEQ_RESET;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seq_reg       <= seq_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/core/sequenced_packet_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequenced_packet_framer: framer with sequence number and modular checksum
// Input words carry a payload byte and a last flag. Output words carry a byte,
// its kind (start, sequence, payload, checksum) and an end-of-run mark on the
// last word caused by one input word. A frame opens with the start byte and
// the sequence number, passes every payload byte, and closes with the sum of
// sequence number and payload modulo the configured modulus.
// Both streams use valid and stall; the register port uses valid and ready
// and is always ready. Registers are to be written only while the block is
// idle; the block itself does not enforce this. Input words enter a two-entry
// queue, so the input side keeps accepting while the output is stalled until
// the queue fills. Each payload word needs one modulo pass (three remainder
// bits per cycle), and a word that opens a frame needs a second pass for the
// sequence number first. These passes set the throughput: the builder takes
// no new word from the queue until the last one has been emitted.
// A stalled output word holds; the builder waits until it is taken.
// After reset the registers hold their defaults, the sequence number is 1 and
// no frame is open; there is no start-up pass.
// ----------------------------------------------------------------------------
module sequenced_packet_framer #(
    parameter int QUEUE_DEPTH = spf_pkg::QUEUE_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               byte_valid,
    output logic                               byte_stall,
    input  spf_pkg::in_word_t                  byte_word,
    output logic                               frame_valid,
    input  logic                               frame_stall,
    output spf_pkg::out_word_t                 frame_word,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [spf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [spf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import spf_pkg::*;

    logic [7:0] start_byte_reg;
    logic [7:0] start_byte_next;
    logic [8:0] modulus_reg;
    logic [8:0] modulus_next;
    logic [7:0] seq_first_reg;
    logic [7:0] seq_first_next;
    logic [7:0] seq_wrap_reg;
    logic [7:0] seq_wrap_next;
    cfg_t       cfg;
    logic       q_full;
    logic       q_empty;
    logic       q_push;
    logic       q_pop;
    entry_t     q_entry;
    entry_t     q_head;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        start_byte_next = start_byte_reg;
        modulus_next    = modulus_reg;
        seq_first_next  = seq_first_reg;
        seq_wrap_next   = seq_wrap_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_START_BYTE: start_byte_next = cfg_data[7:0];
                REG_MODULUS:    modulus_next    = cfg_data;
                REG_SEQ_FIRST:  seq_first_next  = cfg_data[7:0];
                REG_SEQ_WRAP:   seq_wrap_next   = cfg_data[7:0];
                default:        start_byte_next = start_byte_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_BYTE_RESET;
            modulus_reg    <= MODULUS_RESET;
            seq_first_reg  <= SEQ_FIRST_RESET;
            seq_wrap_reg   <= SEQ_WRAP_RESET;
        end
        else
        begin
            start_byte_reg <= start_byte_next;
            modulus_reg    <= modulus_next;
            seq_first_reg  <= seq_first_next;
            seq_wrap_reg   <= seq_wrap_next;
        end
    end

    // A modulus of zero or above 256 behaves as 256.
    always_comb
    begin
        cfg.start_byte     = start_byte_reg;
        cfg.seq_first      = seq_first_reg;
        cfg.seq_wrap_limit = seq_wrap_reg;
        if (modulus_reg == '0 || modulus_reg > MODULUS_MAX)
        begin
            cfg.modulus = MODULUS_MAX;
        end
        else
        begin
            cfg.modulus = modulus_reg;
        end
    end

    spf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_word  (byte_word),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (q_entry)
    );

    spf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    spf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame_word  (frame_word)
    );

endmodule
